/* rtl/core/selp_pkg.sv */
// Shared types and constants of the serial epoch line parser.
package selp_pkg;

    localparam int LINE_BUFFER_BYTES = 64;
    localparam int LINE_CNT_W        = $clog2(LINE_BUFFER_BYTES);

    localparam int BYTE_W   = 8;
    localparam int MS_W     = 32;
    localparam int EPOCH_W  = 31;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = 40;   // 8 + 32, already whole bytes
    localparam int OUT_DATA_W = 96;   // 31 + 1 + 31 + 32 = 95, padded
    localparam int OUT_USER_W = STATUS_W;

    localparam int PREFIX_LEN = 5;
    localparam int PREFIX_W   = 3;

    localparam logic [EPOCH_W-1:0] MAX_VALUE = {EPOCH_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_SYNCED   = 2'd0,
        ST_REJECTED = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // "TIME:" one character per position
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [PREFIX_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h54;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h4D;
            3'd3:    c = 8'h45;
            3'd4:    c = 8'h3A;
            default: c = 8'hFF;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/serial_epoch_line_parser.sv */
// Top level: per-byte TIME:<decimal> line parser with a two-entry result buffer.
//
//  channel   dir  tdata (low bit up)                                 tuser
//  s_axis    in   data_byte[7:0], now_ms[39:8]                       -
//  m_axis    out  line_epoch[30:0], has_synced[31],                  status[1:0]
//                 last_epoch[62:32], last_sync_ms[94:63], zero[95]
//
// One word per cycle while s_axis_tready is high: each byte updates the line state in the cycle it is taken.
// A newline or an overflow gives a result word, registered before it appears on m_axis.
// Results go to an output register with a skid register behind it, so bytes keep
// flowing while one result waits; s_axis_tready drops only when both are full.
// Reset (synchronous, active low) clears the line state, the sync record and the
// result buffer.
module serial_epoch_line_parser
    import selp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // data_byte, now_ms
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // line_epoch, has_synced, last_epoch,
                                                  // last_sync_ms, pad
    output logic [OUT_USER_W-1:0] m_axis_tuser    // status
);

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_SPACE  = 3'd1,
        PH_SIGNED = 3'd2,
        PH_DIGITS = 3'd3,
        PH_ENDED  = 3'd4,
        PH_BAD    = 3'd5
    } t_phase;

    t_phase                r_phase,      n_phase;
    logic [PREFIX_W-1:0]   r_prefix_pos, n_prefix_pos;
    logic                  r_minus,      n_minus;
    logic                  r_digit_seen, n_digit_seen;
    logic [EPOCH_W-1:0]    r_value,      n_value;
    logic [LINE_CNT_W-1:0] r_line_count, n_line_count;
    logic                  r_synced,     n_synced;
    logic [EPOCH_W-1:0]    r_sync_epoch, n_sync_epoch;
    logic [MS_W-1:0]       r_sync_ms,    n_sync_ms;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic                  r_skid_valid;
    logic [OUT_DATA_W-1:0] r_skid_data;
    logic [OUT_USER_W-1:0] r_skid_user;

    logic                  accept;
    logic                  pop;
    logic [BYTE_W-1:0]     in_byte;
    logic [MS_W-1:0]       in_ms;
    logic                  is_digit;
    logic                  is_space;
    logic [EPOCH_W+3:0]    mac;
    logic                  line_ok;
    logic                  res_valid;
    t_status               res_status;
    logic [EPOCH_W-1:0]    res_epoch;
    logic [OUT_DATA_W-1:0] res_data;

    assign in_byte = s_axis_tdata[BYTE_W-1:0];
    assign in_ms   = s_axis_tdata[BYTE_W+MS_W-1:BYTE_W];

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                      (in_byte == CH_VT) || (in_byte == CH_FF);

    // acc * 10 + digit, as two shifts and adds
    assign mac = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1) +
                 (EPOCH_W+4)'(in_byte - CH_ZERO);

    assign line_ok = ((r_phase == PH_DIGITS) || (r_phase == PH_ENDED)) &&
                     r_digit_seen && !r_minus && (r_value != '0);

    always_comb begin
        n_phase      = r_phase;
        n_prefix_pos = r_prefix_pos;
        n_minus      = r_minus;
        n_digit_seen = r_digit_seen;
        n_value      = r_value;
        n_line_count = r_line_count;
        n_synced     = r_synced;
        n_sync_epoch = r_sync_epoch;
        n_sync_ms    = r_sync_ms;
        res_valid    = 1'b0;
        res_status   = ST_REJECTED;
        res_epoch    = '0;

        if (accept && (in_byte != CH_CR)) begin
            if (in_byte == CH_LF) begin
                res_valid = 1'b1;
                if (line_ok) begin
                    res_status   = ST_SYNCED;
                    res_epoch    = r_value;
                    n_synced     = 1'b1;
                    n_sync_epoch = r_value;
                    n_sync_ms    = in_ms;
                end
                n_phase      = PH_PREFIX;
                n_prefix_pos = '0;
                n_minus      = 1'b0;
                n_digit_seen = 1'b0;
                n_value      = '0;
                n_line_count = '0;
            end else if (r_line_count < LINE_CNT_W'(LINE_BUFFER_BYTES - 1)) begin
                n_line_count = r_line_count + 1'b1;
                case (r_phase)
                    PH_PREFIX: begin
                        if (in_byte == prefix_char(r_prefix_pos)) begin
                            n_prefix_pos = r_prefix_pos + 1'b1;
                            if (r_prefix_pos == PREFIX_W'(PREFIX_LEN - 1)) begin
                                n_phase = PH_SPACE;
                            end
                        end else begin
                            n_phase = PH_BAD;
                        end
                    end
                    PH_SPACE, PH_SIGNED, PH_DIGITS: begin
                        if (is_digit) begin
                            n_value      = (mac > {4'b0, MAX_VALUE}) ? MAX_VALUE
                                                                     : mac[EPOCH_W-1:0];
                            n_digit_seen = 1'b1;
                            n_phase      = PH_DIGITS;
                        end else if ((r_phase == PH_SPACE) && is_space) begin
                            n_phase = PH_SPACE;
                        end else if ((r_phase == PH_SPACE) &&
                                     ((in_byte == CH_PLUS) || (in_byte == CH_MINUS))) begin
                            n_minus = (in_byte == CH_MINUS);
                            n_phase = PH_SIGNED;
                        end else if ((r_phase == PH_DIGITS) && (in_byte == CH_NUL)) begin
                            n_phase = PH_ENDED;
                        end else begin
                            n_phase = PH_BAD;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end else begin
                // line too long: drop the byte and start over
                res_valid    = 1'b1;
                res_status   = ST_OVERFLOW;
                n_phase      = PH_PREFIX;
                n_prefix_pos = '0;
                n_minus      = 1'b0;
                n_digit_seen = 1'b0;
                n_value      = '0;
                n_line_count = '0;
            end
        end
    end

    assign res_data = {1'b0, n_sync_ms, n_sync_epoch, n_synced, res_epoch};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PREFIX;
            r_prefix_pos <= '0;
            r_minus      <= 1'b0;
            r_digit_seen <= 1'b0;
            r_value      <= '0;
            r_line_count <= '0;
            r_synced     <= 1'b0;
            r_sync_epoch <= '0;
            r_sync_ms    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_prefix_pos <= n_prefix_pos;
            r_minus      <= n_minus;
            r_digit_seen <= n_digit_seen;
            r_value      <= n_value;
            r_line_count <= n_line_count;
            r_synced     <= n_synced;
            r_sync_epoch <= n_sync_epoch;
            r_sync_ms    <= n_sync_ms;

            if (!r_out_valid || pop) begin
                if (r_skid_valid) begin
                    // skid full means no word was taken this cycle
                    r_out_valid  <= 1'b1;
                    r_out_data   <= r_skid_data;
                    r_out_user   <= r_skid_user;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                    r_out_data  <= res_data;
                    r_out_user  <= res_status;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= res_data;
                r_skid_user  <= res_status;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

/* rtl/core/selp_checker.sv */
// Port-level checks of the serial epoch line parser, bound to the top level.
module selp_checker
    import selp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // an input word offered but not taken stays on the bus
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && !s_axis_tready) |=> (s_axis_tvalid && $stable(s_axis_tdata)))
        else $error("input word changed while stalled");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_SYNCED || m_axis_tuser == ST_REJECTED ||
                           m_axis_tuser == ST_OVERFLOW))
        else $error("undefined status code");

    a_no_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_SYNCED) |-> (m_axis_tdata[30:0] == '0))
        else $error("epoch reported on a line that did not sync");

    // a synced line also shows up as the stored sync record
    a_sync_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_SYNCED) |->
        (m_axis_tdata[31] && m_axis_tdata[62:32] == m_axis_tdata[30:0] &&
         m_axis_tdata[30:0] != '0))
        else $error("synced line disagrees with the sync record");

endmodule

bind serial_epoch_line_parser selp_checker u_selp_checker (.*);

/* bench/tb_serial_epoch_line_parser.sv */
// Self-checking testbench of the serial epoch line parser: directed and random byte streams.
`timescale 1ns / 1ps

module tb_serial_epoch_line_parser;
    import selp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BYTES = 1100;
    localparam int HOLD_AT = 300;      // accepted words before the long receiver hold-off
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [2:0] {
        LP_HEAD, LP_SPACE, LP_SIGN, LP_DIGITS, LP_ENDED, LP_BAD
    } t_line_phase;

    typedef struct packed {
        t_status            status;
        logic [EPOCH_W-1:0] line_epoch;
        logic               has_synced;
        logic [EPOCH_W-1:0] last_epoch;
        logic [MS_W-1:0]    last_sync_ms;
    } t_sync_report;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [MS_W-1:0]   ms;
        bit                drain;   // hold this word until all reports are in
    } t_serial_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // data_byte, now_ms
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // line_epoch, has_synced, last_epoch,
                                                 // last_sync_ms, pad
    logic [OUT_USER_W-1:0] m_axis_tuser;         // status

    serial_epoch_line_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    t_serial_word  word_q[$];
    t_sync_report  report_q[$];
    int            total_words = 0;
    int            accepted_words = 0;
    int            err_cnt = 0;
    int            cycle = 0;
    bit            in_taken = 1'b0;
    int            tx_gap = 0;
    int            rx_stall = 0;
    bit            hold_done = 1'b0;

    // stimulus generation state
    logic [MS_W-1:0] ms_clock = '0;
    bit              rand_mode = 1'b0;
    bit              drain_next = 1'b0;
    int              feed_cnt = 0;

    // predicted parser state
    logic [BYTE_W-1:0]     tag_chars [PREFIX_LEN] = '{"T", "I", "M", "E", ":"};
    logic [PREFIX_W-1:0]   tag_pos = '0;
    t_line_phase           phase = LP_HEAD;
    logic                  minus_seen = 1'b0;
    logic                  digit_seen = 1'b0;
    logic [EPOCH_W-1:0]    acc = '0;
    int                    line_len = 0;
    logic                  synced = 1'b0;
    logic [EPOCH_W-1:0]    sync_epoch = '0;
    logic [MS_W-1:0]       sync_ms = '0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        // quiet window: no idling at all
        if ((cycle % 1000) < 150) return 0;
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic clear_line();
        tag_pos    = '0;
        phase      = LP_HEAD;
        minus_seen = 1'b0;
        digit_seen = 1'b0;
        acc        = '0;
        line_len   = 0;
    endtask

    task automatic predict_sync(input logic [BYTE_W-1:0] b, input logic [MS_W-1:0] ms);
        t_sync_report rep;
        logic [63:0]  v;
        bit           ok;
        bit           is_digit;
        if (b == CH_CR) return;
        rep = '0;
        if (b == CH_LF) begin
            ok = (phase == LP_DIGITS || phase == LP_ENDED) && digit_seen && !minus_seen
                 && acc != '0;
            if (ok) begin
                rep.line_epoch = acc;
                synced     = 1'b1;
                sync_epoch = acc;
                sync_ms    = ms;
                rep.status = ST_SYNCED;
            end else begin
                rep.status = ST_REJECTED;
            end
            clear_line();
        end else if (line_len < LINE_BUFFER_BYTES - 1) begin
            line_len++;
            is_digit = (b >= CH_ZERO && b <= CH_NINE);
            case (phase)
                LP_HEAD: begin
                    if (tag_pos < PREFIX_LEN && b == tag_chars[tag_pos]) begin
                        tag_pos++;
                        if (tag_pos == PREFIX_LEN) phase = LP_SPACE;
                    end else begin
                        phase = LP_BAD;
                    end
                end
                LP_SPACE, LP_SIGN, LP_DIGITS: begin
                    if (is_digit) begin
                        v = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
                        acc = (v > 64'(MAX_VALUE)) ? MAX_VALUE : v[EPOCH_W-1:0];
                        digit_seen = 1'b1;
                        phase = LP_DIGITS;
                    end else if (phase == LP_SPACE && (b == CH_SPACE || b == CH_TAB
                                 || b == CH_VT || b == CH_FF)) begin
                        // leading white space skipped
                    end else if (phase == LP_SPACE && (b == CH_PLUS || b == CH_MINUS)) begin
                        minus_seen = (b == CH_MINUS);
                        phase = LP_SIGN;
                    end else if (phase == LP_DIGITS && b == CH_NUL) begin
                        phase = LP_ENDED;
                    end else begin
                        phase = LP_BAD;
                    end
                end
                default: ;
            endcase
            return;
        end else begin
            clear_line();
            rep.status = ST_OVERFLOW;
        end
        rep.has_synced   = synced;
        rep.last_epoch   = sync_epoch;
        rep.last_sync_ms = sync_ms;
        report_q.push_back(rep);
    endtask

    // ---------------- stimulus building ----------------
    task automatic push_b(input logic [BYTE_W-1:0] b);
        t_serial_word w;
        if (rand_mode && b != CH_CR && $urandom_range(24) == 0) begin
            w.data = CH_CR;
            w.ms = ms_clock;
            w.drain = drain_next;
            drain_next = 1'b0;
            word_q.push_back(w);
        end
        w.data = b;
        w.ms = ms_clock;
        w.drain = drain_next;
        drain_next = 1'b0;
        word_q.push_back(w);
        if (b != CH_CR) feed_cnt++;
        ms_clock += $urandom_range(0, 3);
        if (rand_mode && $urandom_range(19) == 0) ms_clock = $urandom;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_b(s[i]);
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++) push_b(CH_ZERO + 8'($urandom_range(9)));
    endtask

    function automatic logic [BYTE_W-1:0] rand_space();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_not_lf();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        return (b == CH_LF) ? 8'h78 : b;
    endfunction

    task automatic gen_line();
        int kind;
        int n;
        int r;
        kind = $urandom_range(99);
        if (kind < 70) begin
            // well-formed shape, sometimes spoiled at the end
            push_text("TIME:");
            if ($urandom_range(3) == 0) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) push_b(rand_space());
            end
            r = $urandom_range(9);
            if (r == 0) push_b(CH_PLUS);
            else if (r == 1) push_b(CH_MINUS);
            push_digits(($urandom_range(9) == 0) ? $urandom_range(11, 15)
                                                 : $urandom_range(1, 10));
            r = $urandom_range(99);
            if (r < 8) begin
                push_b(CH_NUL);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) push_b(rand_not_lf());
            end else if (r < 15) begin
                push_b(rand_not_lf());
            end else if (r < 20) begin
                push_b(CH_SPACE);
            end
        end else if (kind < 82) begin
            // broken prefix
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) push_b(tag_chars[i]);
            push_b(($urandom_range(3) == 0) ? CH_NUL : rand_not_lf());
            push_digits($urandom_range(0, 3));
        end else if (kind < 96) begin
            // raw noise, newlines inside included
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++) push_b(8'($urandom));
        end else begin
            // long line around the buffer limit
            push_text("TIME:");
            push_digits(($urandom_range(1) == 0) ? 58 : $urandom_range(55, 70));
        end
        push_b(CH_LF);
    endtask

    // ---------------- driver ----------------
    always @(negedge i_clk) begin
        t_serial_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // word still offered
        end else if (tx_gap > 0) begin
            tx_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (word_q.size() != 0 && !(word_q[0].drain && report_q.size() != 0)) begin
            w = word_q.pop_front();
            s_axis_tdata  <= {w.ms, w.data};
            s_axis_tvalid <= 1'b1;
            tx_gap = pick_gap();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------- receiver ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && accepted_words >= HOLD_AT) begin
            hold_done = 1'b1;
            rx_stall = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_stall = pick_gap();
        end
    end

    // ---------------- monitor, predictor and checker ----------------
    always @(posedge i_clk) begin
        t_sync_report want;
        t_sync_report got;
        cycle++;
        if (cycle >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                accepted_words++;
                predict_sync(s_axis_tdata[BYTE_W-1:0], s_axis_tdata[BYTE_W +: MS_W]);
            end
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.status       = t_status'(m_axis_tuser);
                got.line_epoch   = m_axis_tdata[30:0];
                got.has_synced   = m_axis_tdata[31];
                got.last_epoch   = m_axis_tdata[62:32];
                got.last_sync_ms = m_axis_tdata[94:63];
                if (report_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected report: status %0d epoch %0d", got.status,
                                 got.line_epoch);
                end else begin
                    want = report_q.pop_front();
                    if (got.status !== want.status || got.line_epoch !== want.line_epoch
                        || got.has_synced !== want.has_synced
                        || got.last_epoch !== want.last_epoch
                        || got.last_sync_ms !== want.last_sync_ms) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"report mismatch: exp status %0d epoch %0d synced %0d ",
                                      "last %0d ms %0h / got status %0d epoch %0d synced %0d ",
                                      "last %0d ms %0h"},
                                     want.status, want.line_epoch, want.has_synced,
                                     want.last_epoch, want.last_sync_ms,
                                     got.status, got.line_epoch, got.has_synced,
                                     got.last_epoch, got.last_sync_ms);
                    end
                end
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        int start_cnt;
        bit mid_drain_done;
        mid_drain_done = 1'b0;

        // directed lines
        push_b(CH_LF);                                  // empty line
        push_text("TIME:1"); ms_clock = '0; push_b(CH_LF);
        push_text("TIME:2147483647"); ms_clock = '1; push_b(CH_LF);
        push_text("TIME:99999999999\n");                // saturates
        push_text("TIME:0\n");                          // zero value
        push_text("TIME:-5\n");
        push_text("TIME:-0\n");
        push_text("TIME:+42"); push_b(CH_CR); push_b(CH_LF);
        push_text("TIME:");
        push_b(CH_TAB); push_b(CH_VT); push_b(CH_FF); push_b(CH_SPACE);
        push_text("7\n");
        push_text("TIME:12"); push_b(CH_NUL); push_b(8'hFF); push_text("x:\n");
        push_text("TIME"); push_b(CH_NUL); push_text(":5\n");     // NUL inside prefix
        push_text("TIME:"); push_b(CH_NUL); push_text("5\n");     // NUL before digits
        push_text("TIME: +\n");
        push_text("TIME:++1\n");
        push_text("TIME:12a\n");
        push_text("TIME:5 \n");
        push_text("TIME:\n");
        push_text("time:5\n");
        // longest line that still fits, with a dropped CR
        push_text("TIME:"); push_digits(29); push_b(CH_CR); push_digits(29);
        push_b(CH_LF);
        // one byte too many, then the newline ends an empty line
        push_text("TIME:"); push_digits(59); push_b(CH_LF);
        for (int i = 0; i < 63; i++) push_b(8'h41);
        push_b(CH_LF);

        // random part
        rand_mode = 1'b1;
        drain_next = 1'b1;
        start_cnt = feed_cnt;
        while (feed_cnt < start_cnt + RANDOM_BYTES) begin
            if (!mid_drain_done && feed_cnt > start_cnt + RANDOM_BYTES / 2) begin
                mid_drain_done = 1'b1;
                drain_next = 1'b1;
            end
            gen_line();
        end
        total_words = word_q.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_words == total_words);
        wait (report_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && report_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
